// ----- rtl/upud_pkg.sv -----
// upud_pkg: shared types, constants and helper functions for the URI percent decoder.
// Used by upud_alu, upud_seq and the top level uri_percent_utf8_decoder.
package upud_pkg;

	// Widths
	localparam int UNIT_W = 16;
	localparam int CP_W   = 21;
	localparam int HEX_W  = 7;
	localparam int STORE_DEPTH = 8;
	localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

	// Longest UTF-8 sequence accepted
	localparam logic [2:0] MAX_SEQ_OCTETS = 3'd4;

	// Configuration register map
	localparam int          ADDR_W           = 2;
	localparam logic [ADDR_W-1:0] ADDR_RSV_MASK = '0;
	localparam logic [1:0]  RSV_MASK_RESET   = 2'd1;

	// Characters and code point bounds
	localparam logic [UNIT_W-1:0] PCT_CHAR     = 16'h0025;
	localparam logic [CP_W-1:0]   SURR_LO      = 21'h00D800;
	localparam logic [CP_W-1:0]   SURR_HI      = 21'h00DFFF;
	localparam logic [CP_W-1:0]   CP_MAX       = 21'h10FFFF;
	localparam logic [CP_W-1:0]   SUPP_BASE    = 21'h010000;
	localparam logic [CP_W-1:0]   HI_SURR_BASE = 21'h00D800;
	localparam logic [CP_W-1:0]   LO_SURR_BASE = 21'h00DC00;

	// Shared adder request and response
	typedef struct packed {
		logic [CP_W-1:0] a;
		logic [CP_W-1:0] b;
		logic            sub;
	} alu_req_t;

	typedef struct packed {
		logic [CP_W-1:0] sum;
		logic            borrow;
	} alu_rsp_t;

	// One result transaction
	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic              last_of_run;
		logic              err;
		logic              eos;
	} res_t;

	// ASCII property table: bit 0 reserved, bit 1 unreserved
	localparam logic [1:0] URI_PROPS [128] = '{
		2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
		2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
		2'd0,2'd2,2'd0,2'd1,2'd1,2'd0,2'd1,2'd2,2'd2,2'd2,2'd2,2'd1,2'd1,2'd2,2'd2,2'd1,
		2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd1,2'd0,2'd1,2'd0,2'd1,
		2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,
		2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd0,2'd0,2'd0,2'd0,2'd2,
		2'd0,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,
		2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd0,2'd0,2'd0,2'd2,2'd0
	};

	// Hex digit decode: {valid, value}
	function automatic logic [4:0] hex_val(input logic [UNIT_W-1:0] u);
		logic [4:0] r;
		r = 5'd0;
		if (u >= 16'h0030 && u <= 16'h0039) begin
			r = {1'b1, u[3:0]};
		end else if ((u >= 16'h0061 && u <= 16'h0066) || (u >= 16'h0041 && u <= 16'h0046)) begin
			r = {1'b1, u[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Leading ones of a lead octet, saturated at 5
	function automatic logic [2:0] lead_ones(input logic [7:0] b);
		logic [2:0] n;
		priority casez (b)
			8'b0???????: n = 3'd0;
			8'b10??????: n = 3'd1;
			8'b110?????: n = 3'd2;
			8'b1110????: n = 3'd3;
			8'b11110???: n = 3'd4;
			default:     n = 3'd5;
		endcase
		return n;
	endfunction

	// Smallest code point allowed for a sequence length (overlong check)
	function automatic logic [CP_W-1:0] min_bound(input logic [2:0] n);
		logic [CP_W-1:0] r;
		unique case (n)
			3'd2:    r = 21'h000080;
			3'd3:    r = 21'h000800;
			default: r = SUPP_BASE;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/uri_percent_utf8_decoder.sv -----
// uri_percent_utf8_decoder: top level, register port and stream ports.
// Depends on upud_pkg and instantiates upud_seq.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------------
//  s_*      | in        | s_tvalid / s_tready    | tdata: code_unit; tlast: last_of_string
//  m_*      | out       | m_tvalid / m_tready    | tdata: out_unit; tlast: last_of_run;
//           |           |                        | tuser: decode_error, end_of_string
//  apb      | in        | psel, penable, pready  | reg 0 at 0x0: reserved_set_mask
//
// A unit with results (up to three) emits them one per output handshake. A unit closing a
// multi-octet sequence first runs five check steps, and two more for a surrogate pair, all on
// the one shared adder.
// s_tready is low while an item is checked or emitted; emission waits on m_tready.
// Reset is asynchronous; no clearing pass is needed.
module uri_percent_utf8_decoder import upud_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// APB configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// Input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // [15:0] code_unit
	input  logic              s_tlast,
	// Output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // [15:0] out_unit
	output logic              m_tlast,
	output logic [1:0]        m_tuser    // [0] decode_error, [1] end_of_string
);

	logic [1:0] rsv_mask_q;
	res_t       res;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsv_mask_q <= RSV_MASK_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_RSV_MASK) begin
			rsv_mask_q <= pwdata[1:0];
		end
	end

	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_RSV_MASK) prdata = {30'd0, rsv_mask_q};
	end

	upud_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.rsv_mask  (rsv_mask_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_unit   (s_tdata),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = res.unit;
	assign m_tlast = res.last_of_run;
	assign m_tuser = {res.eos, res.err};

endmodule

// ----- rtl/upud_alu.sv -----
// upud_alu: shared 21-bit add/subtract unit with borrow flag.
// Depends on upud_pkg (alu_req_t, alu_rsp_t).
module upud_alu import upud_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [CP_W:0] total;

	// a + b, or a - b as a + ~b + 1; borrow when a < b
	always_comb begin
		total = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{CP_W{1'b0}}, req.sub};
		rsp.sum    = total[CP_W-1:0];
		rsp.borrow = req.sub & ~total[CP_W];
	end

endmodule

// ----- rtl/upud_seq.sv -----
// upud_seq: parse state, sequencer for code point checks and result emission.
// Depends on upud_pkg and instantiates upud_alu.
module upud_seq import upud_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        rsv_mask,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [UNIT_W-1:0] in_unit,
	input  logic              in_last,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              out_res
);

	typedef enum logic [3:0] {
		ST_IN, ST_EMIT, ST_CHK_MIN, ST_CHK_SLO, ST_CHK_SHI, ST_CHK_MAX, ST_CHK_BMP, ST_HI, ST_LO
	} state_t;

	typedef enum logic [2:0] {PH_IDLE, PH_HEX1, PH_HEX2, PH_PCT, PH_DRAIN} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	logic [2:0]        exp_q;
	logic [2:0]        seen_q;
	logic [3:0]        hn_q;
	logic [CP_W-1:0]   acc_q;
	logic              last_q;
	logic              ge_q;
	logic [UNIT_W-1:0] res_q [3];
	logic [1:0]        cnt_q;
	logic              err_q;
	logic              eos_q;
	logic              out_valid_q;
	res_t              out_q;
	logic [HEX_W-1:0]  store_q [STORE_DEPTH];

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	upud_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Input decode
	logic [4:0]              hex;
	logic [7:0]              oct;
	logic [2:0]              n_lead;
	logic [2:0]              seen_inc;
	logic [STORE_IDX_W-1:0]  slot;
	logic                    d_fail, d_emit, d_copy, d_chk, d_hn_ld, d_st_wr;
	logic                    d_lead, d_cont, d_clr;
	logic [STORE_IDX_W-1:0]  d_st_idx;
	logic [UNIT_W-1:0]       d_unit;
	phase_t                  d_ph;

	always_comb begin
		hex      = hex_val(in_unit);
		oct      = {hn_q, hex[3:0]};
		n_lead   = lead_ones(oct);
		seen_inc = seen_q + 3'd1;
		slot     = {seen_q[1:0], 1'b0};
		d_fail   = 1'b0;
		d_emit   = 1'b0;
		d_copy   = 1'b0;
		d_chk    = 1'b0;
		d_hn_ld  = 1'b0;
		d_st_wr  = 1'b0;
		d_st_idx = slot;
		d_lead   = 1'b0;
		d_cont   = 1'b0;
		d_clr    = 1'b0;
		d_unit   = in_unit;
		d_ph     = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (in_unit != PCT_CHAR) begin
					d_emit = 1'b1;
				end else if (in_last) begin
					d_fail = 1'b1;
				end else begin
					d_clr = 1'b1;
					d_ph  = PH_HEX1;
				end
			end
			PH_PCT: begin
				if (in_unit != PCT_CHAR || in_last) d_fail = 1'b1;
				else d_ph = PH_HEX1;
			end
			PH_HEX1: begin
				if (!hex[4] || in_last) begin
					d_fail = 1'b1;
				end else begin
					d_hn_ld = 1'b1;
					d_st_wr = 1'b1;
					d_ph    = PH_HEX2;
				end
			end
			PH_HEX2: begin
				if (!hex[4]) begin
					d_fail = 1'b1;
				end else begin
					d_st_wr  = 1'b1;
					d_st_idx = slot | STORE_IDX_W'(1);
					if (seen_q == 3'd0) begin
						if (!oct[7]) begin
							d_ph = PH_IDLE;
							if ((URI_PROPS[oct[6:0]] & rsv_mask) != 2'd0) begin
								d_copy = 1'b1;
							end else begin
								d_emit = 1'b1;
								d_unit = {8'd0, oct};
							end
						end else if (n_lead < 3'd2 || n_lead > MAX_SEQ_OCTETS || in_last) begin
							d_fail = 1'b1;
						end else begin
							d_lead = 1'b1;
							d_ph   = PH_PCT;
						end
					end else if (oct[7:6] != 2'b10) begin
						d_fail = 1'b1;
					end else if (seen_inc < exp_q) begin
						if (in_last) begin
							d_fail = 1'b1;
						end else begin
							d_cont = 1'b1;
							d_ph   = PH_PCT;
						end
					end else begin
						d_cont = 1'b1;
						d_chk  = 1'b1;
					end
				end
			end
			PH_DRAIN: begin
				if (in_last) d_ph = PH_IDLE;
			end
			default: d_ph = PH_IDLE;
		endcase
	end

	// Shared adder operands for each check step
	always_comb begin
		alu_req.a   = acc_q;
		alu_req.b   = '0;
		alu_req.sub = 1'b0;
		unique case (state_q)
			ST_CHK_MIN: begin
				alu_req.b   = min_bound(exp_q);
				alu_req.sub = 1'b1;
			end
			ST_CHK_SLO: begin
				alu_req.b   = SURR_LO;
				alu_req.sub = 1'b1;
			end
			ST_CHK_SHI: begin
				alu_req.a   = SURR_HI;
				alu_req.b   = acc_q;
				alu_req.sub = 1'b1;
			end
			ST_CHK_MAX: begin
				alu_req.a   = CP_MAX;
				alu_req.b   = acc_q;
				alu_req.sub = 1'b1;
			end
			ST_CHK_BMP: begin
				alu_req.b   = SUPP_BASE;
				alu_req.sub = 1'b1;
			end
			ST_HI: begin
				alu_req.a = {11'd0, acc_q[19:10]};
				alu_req.b = HI_SURR_BASE;
			end
			ST_LO: begin
				alu_req.a = {11'd0, acc_q[9:0]};
				alu_req.b = LO_SURR_BASE;
			end
			default: begin
				alu_req.sub = 1'b0;
			end
		endcase
	end

	// Malformed escape detected this cycle
	logic fail_now;
	logic fail_last;

	always_comb begin
		fail_now  = ((state_q == ST_IN) && in_valid && d_fail) ||
			((state_q == ST_CHK_MIN) && alu_rsp.borrow) ||
			((state_q == ST_CHK_SHI) && !alu_rsp.borrow && ge_q) ||
			((state_q == ST_CHK_MAX) && alu_rsp.borrow);
		fail_last = (state_q == ST_IN) ? in_last : last_q;
	end

	// Sequencer, parse state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IN;
			phase_q     <= PH_IDLE;
			exp_q       <= '0;
			seen_q      <= '0;
			hn_q        <= '0;
			acc_q       <= '0;
			last_q      <= 1'b0;
			ge_q        <= 1'b0;
			res_q       <= '{default: '0};
			cnt_q       <= '0;
			err_q       <= 1'b0;
			eos_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_EMIT) out_valid_q <= 1'b0;
			// Error: one result, then swallow the rest of the string
			if (fail_now) begin
				res_q[0] <= '0;
				cnt_q    <= 2'd1;
				err_q    <= 1'b1;
				eos_q    <= 1'b1;
				phase_q  <= fail_last ? PH_IDLE : PH_DRAIN;
				exp_q    <= '0;
				seen_q   <= '0;
				state_q  <= ST_EMIT;
			end else begin
				unique case (state_q)
					ST_IN: begin
						if (in_valid) begin
							last_q  <= in_last;
							phase_q <= d_ph;
							if (d_clr) begin
								exp_q  <= '0;
								seen_q <= '0;
							end
							if (d_hn_ld) hn_q <= hex[3:0];
							if (d_lead) begin
								exp_q  <= n_lead;
								seen_q <= 3'd1;
								acc_q  <= {13'd0, oct & (8'h7F >> n_lead)};
							end
							if (d_cont) begin
								acc_q  <= {acc_q[CP_W-7:0], oct[5:0]};
								seen_q <= seen_inc;
							end
							if (d_emit) begin
								res_q[0] <= d_unit;
								cnt_q    <= 2'd1;
								err_q    <= 1'b0;
								eos_q    <= in_last;
								state_q  <= ST_EMIT;
							end
							if (d_copy) begin
								res_q[0] <= PCT_CHAR;
								res_q[1] <= {{(UNIT_W-HEX_W){1'b0}}, store_q[0]};
								res_q[2] <= {{(UNIT_W-HEX_W){1'b0}}, in_unit[HEX_W-1:0]};
								cnt_q    <= 2'd3;
								err_q    <= 1'b0;
								eos_q    <= in_last;
								state_q  <= ST_EMIT;
							end
							if (d_chk) state_q <= ST_CHK_MIN;
						end
					end
					ST_EMIT: begin
						if (!out_valid_q || out_ready) begin
							out_valid_q       <= 1'b1;
							out_q.unit        <= res_q[0];
							out_q.last_of_run <= (cnt_q == 2'd1);
							out_q.err         <= err_q;
							out_q.eos         <= (cnt_q == 2'd1) && eos_q;
							res_q[0]          <= res_q[1];
							res_q[1]          <= res_q[2];
							cnt_q             <= cnt_q - 2'd1;
							if (cnt_q == 2'd1) state_q <= ST_IN;
						end
					end
					ST_CHK_MIN: state_q <= ST_CHK_SLO;
					ST_CHK_SLO: begin
						ge_q    <= !alu_rsp.borrow;
						state_q <= ST_CHK_SHI;
					end
					ST_CHK_SHI: state_q <= ST_CHK_MAX;
					ST_CHK_MAX: state_q <= ST_CHK_BMP;
					ST_CHK_BMP: begin
						phase_q <= PH_IDLE;
						exp_q   <= '0;
						seen_q  <= '0;
						if (alu_rsp.borrow) begin
							res_q[0] <= acc_q[UNIT_W-1:0];
							cnt_q    <= 2'd1;
							err_q    <= 1'b0;
							eos_q    <= last_q;
							state_q  <= ST_EMIT;
						end else begin
							acc_q   <= alu_rsp.sum;
							state_q <= ST_HI;
						end
					end
					ST_HI: begin
						res_q[0] <= alu_rsp.sum[UNIT_W-1:0];
						state_q  <= ST_LO;
					end
					ST_LO: begin
						res_q[1] <= alu_rsp.sum[UNIT_W-1:0];
						cnt_q    <= 2'd2;
						err_q    <= 1'b0;
						eos_q    <= last_q;
						state_q  <= ST_EMIT;
					end
					default: state_q <= ST_IN;
				endcase
			end
		end
	end

	// Hex digit store, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IN && in_valid && !d_fail && d_st_wr) begin
			store_q[d_st_idx] <= in_unit[HEX_W-1:0];
		end
	end

	assign in_ready  = (state_q == ST_IN);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// ----- rtl/upud_checker.sv -----
// upud_checker: port-level assertions on the decoder's output stream.
// Bound to uri_percent_utf8_decoder; no package dependency.
module upud_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast,
	input logic [1:0]  m_tuser
);

	// A stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output transaction changed while stalled");

	// An error result is a lone, string-ending result with a zero unit
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[1] && m_tlast && m_tdata == 16'd0)
		else $error("malformed error result");

	// End of string only on the last result of a run
	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("end of string without end of run");

endmodule

bind uri_percent_utf8_decoder upud_checker u_upud_checker (.*);
